[rtl/core/josephus_permutation_generator_macros.svh]
// Assertion macros used by the checker file of the Josephus permutation generator.
`ifndef JOSEPHUS_PERMUTATION_GENERATOR_MACROS_SVH
`define JOSEPHUS_PERMUTATION_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge and quiet during reset.
`define JP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jp_checker: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge and quiet during reset.
`define JP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jp_checker: next-cycle check failed");

`endif

[rtl/core/jp_pkg.sv]
// Package with the shared constants, types and helper function of the Josephus generator.
package jp_pkg;

	localparam int MAX_PEOPLE = 4096;
	localparam int IDX_W      = $clog2(MAX_PEOPLE);
	localparam int CNT_W      = $clog2(MAX_PEOPLE + 1);
	localparam int PERSON_W   = 13;
	localparam int CFG_W      = 13;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	// Register indexes, taken from paddr[2].
	localparam logic REG_RING_SIZE  = 1'b0;
	localparam logic REG_STEP_COUNT = 1'b1;

	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [PERSON_W-1:0] person_t;
	typedef logic [CFG_W-1:0]    cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic fill_init;
		logic fill_wr;
		logic rot_rd;
		logic rot_wr;
		logic pop_rd;
		logic pop_out;
		logic empty_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic fill_done;
		logic count_zero;
		logic rot_none;
		logic rot_last;
		logic out_free;
	} sts_t;

	function automatic idx_t next_slot(input idx_t idx);
		idx_t res;
		if (idx == idx_t'(MAX_PEOPLE - 1)) begin
			res = '0;
		end else begin
			res = idx + 1'b1;
		end
		return res;
	endfunction

endpackage

[rtl/core/jp_regs.sv]
// Configuration register file behind the APB-style port.
module jp_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [jp_pkg::APB_AW-1:0]  paddr,
	input  logic [jp_pkg::APB_DW-1:0]  pwdata,
	output logic [jp_pkg::APB_DW-1:0]  prdata,
	output logic                       pready,
	output jp_pkg::cfg_t               ring_size_q,
	output jp_pkg::cfg_t               step_count_q
);

	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q  <= jp_pkg::cfg_t'(1);
			step_count_q <= jp_pkg::cfg_t'(1);
		end else if (wr_en) begin
			unique case (paddr[2])
				jp_pkg::REG_RING_SIZE:  ring_size_q  <= pwdata[jp_pkg::CFG_W-1:0];
				jp_pkg::REG_STEP_COUNT: step_count_q <= pwdata[jp_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			jp_pkg::REG_RING_SIZE:  prdata[jp_pkg::CFG_W-1:0] = ring_size_q;
			jp_pkg::REG_STEP_COUNT: prdata[jp_pkg::CFG_W-1:0] = step_count_q;
			default: ;
		endcase
	end

endmodule

[rtl/core/jp_dpath.sv]
// Datapath: survivor queue memory, ring pointers, counters and the result register.
module jp_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  jp_pkg::cmd_t        cmd,
	output jp_pkg::sts_t        sts,
	input  jp_pkg::cfg_t        ring_size,
	input  jp_pkg::cfg_t        step_count,
	output logic                out_valid,
	input  logic                out_ready,
	output jp_pkg::person_t     removed_person,
	output logic                last_of_run,
	output logic                circle_empty
);

	jp_pkg::person_t mem [jp_pkg::MAX_PEOPLE];
	jp_pkg::person_t rdata_q;

	jp_pkg::idx_t head_q;
	jp_pkg::idx_t tail_q;
	jp_pkg::cnt_t count_q;
	jp_pkg::cnt_t fill_idx_q;
	jp_pkg::cnt_t fill_n_q;
	jp_pkg::cfg_t rot_cnt_q;

	jp_pkg::cnt_t fill_n;
	logic         out_valid_q;
	logic         out_load;
	jp_pkg::person_t person_q;
	logic         last_q;
	logic         empty_q;

	// Ring sizes above the queue capacity fill only the capacity.
	assign fill_n = (ring_size > jp_pkg::cfg_t'(jp_pkg::MAX_PEOPLE)) ?
		jp_pkg::cnt_t'(jp_pkg::MAX_PEOPLE) : jp_pkg::cnt_t'(ring_size);

	assign out_load = cmd.pop_out | cmd.empty_out;

	assign sts.fill_done  = (fill_idx_q == fill_n_q);
	assign sts.count_zero = (count_q == '0);
	assign sts.rot_none   = (rot_cnt_q == '0);
	assign sts.rot_last   = (rot_cnt_q == jp_pkg::cfg_t'(1));
	assign sts.out_free   = ~out_valid_q | out_ready;

	// Memory write port: refill or the back of a rotation.
	always_ff @(posedge clk) begin
		if (cmd.fill_wr) begin
			mem[fill_idx_q[jp_pkg::IDX_W-1:0]] <= jp_pkg::person_t'(fill_idx_q + 1'b1);
		end else if (cmd.rot_wr) begin
			mem[tail_q] <= rdata_q;
		end
	end

	// Memory read port, always at the queue front.
	always_ff @(posedge clk) begin
		if (cmd.rot_rd | cmd.pop_rd) begin
			rdata_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			fill_idx_q <= '0;
			fill_n_q   <= '0;
			rot_cnt_q  <= '0;
		end else begin
			if (cmd.start) begin
				rot_cnt_q <= (step_count == '0) ? '0 : step_count - 1'b1;
			end else if (cmd.rot_wr) begin
				rot_cnt_q <= rot_cnt_q - 1'b1;
			end
			if (cmd.fill_init) begin
				fill_idx_q <= '0;
				fill_n_q   <= fill_n;
				head_q     <= '0;
				tail_q     <= (fill_n == jp_pkg::cnt_t'(jp_pkg::MAX_PEOPLE)) ?
					'0 : fill_n[jp_pkg::IDX_W-1:0];
				count_q    <= fill_n;
			end else begin
				if (cmd.fill_wr) begin
					fill_idx_q <= fill_idx_q + 1'b1;
				end
				if (cmd.rot_wr) begin
					head_q <= jp_pkg::next_slot(head_q);
					tail_q <= jp_pkg::next_slot(tail_q);
				end else if (cmd.pop_out) begin
					head_q  <= jp_pkg::next_slot(head_q);
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	// Result register; a new result loads only when the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop_out) begin
			person_q <= rdata_q;
			last_q   <= (count_q == jp_pkg::cnt_t'(1));
			empty_q  <= 1'b0;
		end else if (cmd.empty_out) begin
			person_q <= '0;
			last_q   <= 1'b0;
			empty_q  <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign removed_person = person_q;
	assign last_of_run    = last_q;
	assign circle_empty   = empty_q;

endmodule

[rtl/core/jp_ctrl.sv]
// Controller state machine that sequences refill, rotation and removal.
module jp_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         restart,
	input  jp_pkg::sts_t sts,
	output jp_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_CHECK,
		ST_ROT_RD,
		ST_ROT_WR,
		ST_POP_RD,
		ST_POP_OUT,
		ST_EMPTY_OUT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					if (restart) begin
						cmd.fill_init = 1'b1;
						state_d       = ST_FILL;
					end else begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_FILL: begin
				if (sts.fill_done) begin
					state_d = ST_CHECK;
				end else begin
					cmd.fill_wr = 1'b1;
				end
			end
			ST_CHECK: begin
				if (sts.count_zero) begin
					state_d = ST_EMPTY_OUT;
				end else if (sts.rot_none) begin
					state_d = ST_POP_RD;
				end else begin
					state_d = ST_ROT_RD;
				end
			end
			ST_ROT_RD: begin
				cmd.rot_rd = 1'b1;
				state_d    = ST_ROT_WR;
			end
			ST_ROT_WR: begin
				cmd.rot_wr = 1'b1;
				state_d    = sts.rot_last ? ST_POP_RD : ST_ROT_RD;
			end
			ST_POP_RD: begin
				cmd.pop_rd = 1'b1;
				state_d    = ST_POP_OUT;
			end
			ST_POP_OUT: begin
				if (sts.out_free) begin
					cmd.pop_out = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_EMPTY_OUT: begin
				if (sts.out_free) begin
					cmd.empty_out = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/josephus_permutation_generator.sv]
// Top level of the Josephus permutation generator: registers, controller and datapath.
// Each request transfer yields one result transfer with the next person removed from the
// circle, or an empty answer once the circle is empty. A request without restart makes
// k-1 rotations before the removal, k being step_count (0 counts as 1): every rotation costs
// a read and a write of the single survivor queue memory. A request that finds the circle
// empty loads an empty answer instead. A restart request first refills the queue with
// min(ring_size, 4096) entries at one entry per cycle. The next request is
// taken as soon as the current one has loaded its result, even while that result still
// waits to be taken; a result waits only if the previous one is still held. The queue
// memory is not cleared after reset, so the block is ready at once.
module josephus_permutation_generator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [jp_pkg::APB_AW-1:0]  paddr,
	input  logic [jp_pkg::APB_DW-1:0]  pwdata,
	output logic [jp_pkg::APB_DW-1:0]  prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       restart,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [12:0]                removed_person,
	output logic                       last_of_run,
	output logic                       circle_empty
);

	jp_pkg::cfg_t ring_size;
	jp_pkg::cfg_t step_count;
	jp_pkg::cmd_t cmd;
	jp_pkg::sts_t sts;

	jp_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.ring_size_q  (ring_size),
		.step_count_q (step_count)
	);

	jp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.restart  (restart),
		.sts      (sts),
		.cmd      (cmd)
	);

	jp_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.ring_size      (ring_size),
		.step_count     (step_count),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.removed_person (removed_person),
		.last_of_run    (last_of_run),
		.circle_empty   (circle_empty)
	);

endmodule

[rtl/core/jp_checker.sv]
// Port-level checker for the Josephus generator and its bind to the top level.
`include "josephus_permutation_generator_macros.svh"

module jp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [12:0] removed_person,
	input logic        last_of_run,
	input logic        circle_empty
);

	// An empty answer carries no person and never marks the end of a run.
	`JP_ASSERT_NOW(a_empty_clean, out_valid && circle_empty, removed_person == '0 && !last_of_run)

	// A removed person is always numbered from one upward.
	`JP_ASSERT_NOW(a_person_nonzero, out_valid && !circle_empty, removed_person != '0)

	// In the cycle after a request transfer the block is busy.
	`JP_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)

	// A held result stays put until its transfer.
	`JP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(removed_person))

endmodule

bind josephus_permutation_generator jp_checker u_jp_checker (.*);
